// ===== hw/rtl/scsp_pkg.sv =====
// ----------------------------------------------------------------------------
// scsp_pkg: shared types and constants of the S-curve band profiler
// Widths, fixed-point layout, transaction structs, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scsp_pkg;

  // Fixed-point layout
  localparam int TIME_FRAC_BITS  = 20;
  localparam int BAND_INDEX_BITS = 16;

  // Field widths
  localparam int FREQ_W   = 13;
  localparam int SF_W     = 12;
  localparam int JERK_W   = 16;
  localparam int CFG_W    = 16;
  localparam int PULSE_W  = 13;
  localparam int TOTAL_W  = 24;
  localparam int PRESC_W  = 12;
  localparam int RELOAD_W = 16;
  localparam int D_W      = 12;

  // Divider: dividend wide enough for 2*d << 2F and for 2*k << F
  localparam int DIV_W = 2 * TIME_FRAC_BITS + 13;
  localparam int DVS_W = 16;

  // Band start time, inflection time, curve argument, products
  localparam int T_W  = TIME_FRAC_BITS + BAND_INDEX_BITS + 2;
  localparam int IT_W = TIME_FRAC_BITS + 7;
  localparam int X_W  = IT_W + 1;
  localparam int MA_W = 2 * X_W;
  localparam int P_W  = 3 * X_W;
  localparam int Q_SH = 2 * TIME_FRAC_BITS + 1;
  localparam int Q_W  = 2 * X_W + JERK_W - Q_SH;
  localparam int FS_W = Q_W + 3;

  // Constants
  localparam logic [SF_W-1:0]     PULSE_CLOCK = SF_W'(4000);
  localparam logic [FREQ_W-1:0]   FREQ_MAX    = {FREQ_W{1'b1}};
  localparam logic [PULSE_W-1:0]  PULSES_MAX  = {PULSE_W{1'b1}};
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX   = {TOTAL_W{1'b1}};
  localparam logic [RELOAD_W-1:0] RELOAD_MAX  = {RELOAD_W{1'b1}};
  localparam logic [BAND_INDEX_BITS-1:0] BAND_MAX = {BAND_INDEX_BITS{1'b1}};

  // Register reset values
  localparam logic [SF_W-1:0]   START_FREQ_RST  = SF_W'(500);
  localparam logic [SF_W-1:0]   TARGET_FREQ_RST = SF_W'(2000);
  localparam logic [JERK_W-1:0] JERK_RST        = JERK_W'(3000);

  // Register indexes
  localparam logic [1:0] CFG_START_FREQ  = 2'd0;
  localparam logic [1:0] CFG_TARGET_FREQ = 2'd1;
  localparam logic [1:0] CFG_JERK        = 2'd2;

  // Command codes
  localparam logic [1:0] FUNC_ACCEL = 2'd0;
  localparam logic [1:0] FUNC_DECEL = 2'd1;
  localparam logic [1:0] FUNC_NEXT  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       direction;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   band_freq;
    logic [PULSE_W-1:0]  band_pulses;
    logic [TOTAL_W-1:0]  total_pulses;
    logic [PRESC_W-1:0]  timer_prescale;
    logic [RELOAD_W-1:0] pulse_reload;
    logic                direction_pin;
    logic                last;
    logic                error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV_N, ST_SQRT, ST_DIV_T, ST_SEL, ST_MUL_SQ,
    ST_MUL_C, ST_FREQ, ST_DIV_P, ST_DIV_R, ST_FIN, ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    DIV_OP_N, DIV_OP_T, DIV_OP_P, DIV_OP_R
  } div_op_t;

  typedef enum logic {
    MUL_OP_SQ, MUL_OP_C
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    prep;
    logic    div_start;
    logic    div_cap;
    div_op_t div_sel;
    logic    sqrt_start;
    logic    sqrt_cap;
    logic    sel_seg;
    logic    mul_start;
    mul_op_t mul_sel;
    logic    freq;
    logic    fin;
    logic    err;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic div_done;
    logic sqrt_done;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scsp_div.sv =====
// ----------------------------------------------------------------------------
// scsp_div: restoring divider
// One quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
`default_nettype none

module scsp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [scsp_pkg::DIV_W-1:0]  dividend,
  input  wire logic [scsp_pkg::DVS_W-1:0]  divisor,
  output logic                             done,
  output logic [scsp_pkg::DIV_W-1:0]       quotient
);
  import scsp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DIV_W-1:0] quo_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_dif;
  logic             fits;

  // Trial subtraction of one step
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    rem_dif = rem_sh - {1'b0, dvs_r};
    fits    = rem_sh >= {1'b0, dvs_r};
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) busy_r <= 1'b0;
      end
    end
  end

  // Data: shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scsp_sqrt.sv =====
// ----------------------------------------------------------------------------
// scsp_sqrt: integer square root
// Restoring root, one result bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scsp_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [2*scsp_pkg::IT_W-1:0]  radicand,
  output logic                              done,
  output logic [scsp_pkg::IT_W-1:0]         root
);
  import scsp_pkg::*;

  localparam int CNT_W = $clog2(IT_W);
  localparam int RAD_W = 2 * IT_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0] rad_r;
  logic [IT_W:0]    rem_r;
  logic [IT_W-1:0]  root_r;
  logic [IT_W+2:0]  rem_sh;
  logic [IT_W+2:0]  trial;
  logic [IT_W+2:0]  rem_dif;
  logic             fits;

  // Trial subtraction of one step
  always_comb begin
    rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    rem_dif = rem_sh - trial;
    fits    = rem_sh >= trial;
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(IT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) busy_r <= 1'b0;
      end
    end
  end

  // Data: consume the radicand two bits at a time
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fits ? rem_dif[IT_W:0] : rem_sh[IT_W:0];
      root_r <= {root_r[IT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scsp_mul.sv =====
// ----------------------------------------------------------------------------
// scsp_mul: shift-add multiplier
// One multiplier bit per cycle; the product stays until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module scsp_mul (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [scsp_pkg::MA_W-1:0]  mcand,
  input  wire logic [scsp_pkg::X_W-1:0]   mplier,
  output logic                            done,
  output logic [scsp_pkg::P_W-1:0]        product
);
  import scsp_pkg::*;

  localparam int CNT_W = $clog2(X_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   a_r;
  logic [X_W-1:0]   b_r;
  logic [P_W-1:0]   acc_r;

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(X_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) busy_r <= 1'b0;
      end
    end
  end

  // Data: add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= P_W'(mcand);
      b_r   <= mplier;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[P_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[X_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scsp_dp.sv =====
// ----------------------------------------------------------------------------
// scsp_dp: profiler datapath
// Configuration registers, profile state, the shared divider, root and
// multiplier units, band arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scsp_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire scsp_pkg::cmd_t             cmd,
  output scsp_pkg::sts_t                  sts,
  input  wire scsp_pkg::in_item_t         in_data,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [scsp_pkg::CFG_W-1:0] cfg_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output scsp_pkg::out_item_t             out_data
);
  import scsp_pkg::*;

  // Configuration and profile state
  logic [SF_W-1:0]            start_freq_r;
  logic [SF_W-1:0]            target_freq_r;
  logic [JERK_W-1:0]          jerk_r;
  logic                       running_r;
  logic                       decel_r;
  logic                       seg_r;
  logic [BAND_INDEX_BITS-1:0] band_r;
  logic [IT_W-1:0]            it_r;
  logic [FREQ_W-1:0]          inf_r;
  logic [TOTAL_W-1:0]         pulse_total_r;
  logic                       dir_r;

  // Per-transaction working registers
  logic [1:0]         func_r;
  logic               dir_in_r;
  logic [T_W-1:0]     t_r;
  logic [X_W-1:0]     x_r;
  logic               first_r;
  logic               hold_r;
  logic [FREQ_W-1:0]  f_r;
  logic               last_r;
  logic [PULSE_W-1:0] pulses_r;
  logic [PRESC_W-1:0] period_r;
  logic               out_valid_r;
  out_item_t          out_r;

  // Unit connections
  logic [DIV_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic              sqrt_done;
  logic [IT_W-1:0]   sqrt_root;
  logic [MA_W-1:0]   mul_a;
  logic [X_W-1:0]    mul_b;
  logic              mul_done;
  logic [P_W-1:0]    mul_p;

  // Derived values
  logic [SF_W-1:0]    s_eff;
  logic [JERK_W-1:0]  c_eff;
  logic [FREQ_W-1:0]  inf_new;
  logic [D_W-1:0]     d_val;
  logic [X_W-1:0]     two_it;
  logic               seg_first;
  logic               seg_hold;
  logic [X_W-1:0]     x_new;
  logic [Q_W-1:0]     q_val;
  logic               q_rem;
  logic signed [FS_W-1:0] q_s;
  logic signed [FS_W-1:0] qc_s;
  logic signed [FS_W-1:0] s_s;
  logic signed [FS_W-1:0] m_s;
  logic signed [FS_W-1:0] inf2_s;
  logic signed [FS_W-1:0] f_s;
  logic               last_new;
  logic [FREQ_W-1:0]  f_clamp;
  logic [PULSE_W-1:0] pulses_new;
  logic [PRESC_W-1:0] period_new;
  logic [PRESC_W+PULSE_W-1:0] rl_prod;
  logic [RELOAD_W-1:0] reload;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] tot_sat;

  // Effective settings and profile set-up values
  always_comb begin
    s_eff   = (start_freq_r == '0) ? SF_W'(1) : start_freq_r;
    c_eff   = (jerk_r == '0) ? JERK_W'(1) : jerk_r;
    inf_new = FREQ_W'(({1'b0, s_eff} + {1'b0, target_freq_r}) >> 1);
    if (decel_r) begin
      d_val = ({1'b0, target_freq_r} > inf_r) ?
              D_W'({1'b0, target_freq_r} - inf_r) : '0;
    end else begin
      d_val = (inf_r > {1'b0, s_eff}) ? D_W'(inf_r - {1'b0, s_eff}) : '0;
    end
  end

  // Divider operand selection
  always_comb begin
    case (cmd.div_sel)
      DIV_OP_N: begin
        div_dvd = DIV_W'({d_val, 1'b0}) << (2 * TIME_FRAC_BITS);
        div_dvs = c_eff;
      end
      DIV_OP_T: begin
        div_dvd = DIV_W'({band_r, 1'b0}) << TIME_FRAC_BITS;
        div_dvs = DVS_W'(s_eff);
      end
      DIV_OP_P: begin
        div_dvd = DIV_W'({f_r, 1'b0});
        div_dvs = DVS_W'(s_eff);
      end
      default: begin
        div_dvd = DIV_W'(PULSE_CLOCK);
        div_dvs = DVS_W'(f_r);
      end
    endcase
  end

  // Multiplier operands: x*x first, then c times that square
  always_comb begin
    if (cmd.mul_sel == MUL_OP_SQ) begin
      mul_a = MA_W'(x_r);
      mul_b = x_r;
    end else begin
      mul_a = mul_p[MA_W-1:0];
      mul_b = X_W'(c_eff);
    end
  end

  scsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  scsp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand ((2 * IT_W)'(div_quo)),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  scsp_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // Segment selection: curve argument from band time
  always_comb begin
    two_it    = {it_r, 1'b0};
    seg_first = !seg_r && (t_r < T_W'(it_r));
    seg_hold  = t_r >= T_W'(two_it);
    if (seg_first)      x_new = t_r[X_W-1:0];
    else if (seg_hold)  x_new = '0;
    else                x_new = two_it - t_r[X_W-1:0];
  end

  // Band frequency from the scaled square and the last-band test
  always_comb begin
    q_val  = mul_p[Q_SH +: Q_W];
    q_rem  = |mul_p[Q_SH-1:0];
    q_s    = $signed(FS_W'(q_val));
    qc_s   = q_s + $signed(FS_W'(q_rem));
    s_s    = $signed(FS_W'(s_eff));
    m_s    = $signed(FS_W'(target_freq_r));
    inf2_s = $signed(FS_W'({inf_r, 1'b0}));
    if (first_r) f_s = decel_r ? (m_s - q_s) : (s_s + q_s);
    else if (decel_r) f_s = inf2_s - m_s + q_s;
    else f_s = inf2_s - s_s - qc_s + $signed(FS_W'(1));
    last_new = (!first_r && (hold_r || (decel_r ? (f_s <= s_s) : (f_s >= m_s))))
               || (band_r == BAND_MAX);
    if (f_s < 0) f_clamp = '0;
    else if (f_s > $signed(FS_W'(FREQ_MAX))) f_clamp = FREQ_MAX;
    else f_clamp = f_s[FREQ_W-1:0];
  end

  // Pulse count, timer period, reload and running total
  always_comb begin
    pulses_new = (|div_quo[DIV_W-1:PULSE_W]) ? PULSES_MAX : div_quo[PULSE_W-1:0];
    if (f_r == '0)                period_new = PULSE_CLOCK;
    else if (div_quo == '0)       period_new = PRESC_W'(1);
    else                          period_new = div_quo[PRESC_W-1:0];
    rl_prod = period_r * pulses_r;
    reload  = ({rl_prod, 1'b0} > (PRESC_W + PULSE_W + 1)'(RELOAD_MAX)) ?
              RELOAD_MAX : RELOAD_W'({rl_prod, 1'b0});
    tot_sum = {1'b0, pulse_total_r} + (TOTAL_W + 1)'(pulses_r);
    tot_sat = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_freq_r  <= START_FREQ_RST;
      target_freq_r <= TARGET_FREQ_RST;
      jerk_r        <= JERK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_FREQ:  start_freq_r  <= cfg_data[SF_W-1:0];
        CFG_TARGET_FREQ: target_freq_r <= cfg_data[SF_W-1:0];
        CFG_JERK:        jerk_r        <= cfg_data[JERK_W-1:0];
        default: ;
      endcase
    end
  end

  // Profile state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r     <= 1'b0;
      decel_r       <= 1'b0;
      seg_r         <= 1'b0;
      band_r        <= '0;
      it_r          <= '0;
      inf_r         <= '0;
      pulse_total_r <= '0;
      dir_r         <= 1'b0;
    end else begin
      if (cmd.prep) begin
        decel_r   <= (func_r == FUNC_DECEL);
        if (func_r == FUNC_ACCEL) dir_r <= dir_in_r;
        inf_r     <= inf_new;
        band_r    <= '0;
        seg_r     <= 1'b0;
        running_r <= 1'b1;
      end
      if (cmd.sqrt_cap) it_r <= sqrt_root;
      if (cmd.sel_seg && !seg_first) seg_r <= 1'b1;
      if (cmd.fin) begin
        pulse_total_r <= (last_r && decel_r) ? '0 : tot_sat;
        if (band_r != BAND_MAX) band_r <= band_r + 1'b1;
        if (last_r) running_r <= 1'b0;
      end
    end
  end

  // Working registers of one transaction
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_data.func;
      dir_in_r <= in_data.direction;
    end
    if (cmd.div_cap && cmd.div_sel == DIV_OP_T) t_r <= div_quo[T_W-1:0];
    if (cmd.div_cap && cmd.div_sel == DIV_OP_P) pulses_r <= pulses_new;
    if (cmd.div_cap && cmd.div_sel == DIV_OP_R) period_r <= period_new;
    if (cmd.sel_seg) begin
      x_r     <= x_new;
      first_r <= seg_first;
      hold_r  <= seg_hold;
    end
    if (cmd.freq) begin
      f_r    <= f_clamp;
      last_r <= last_new;
    end
  end

  // Result register: load a finished band or an error, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin || cmd.err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r.band_freq      <= f_r;
      out_r.band_pulses    <= pulses_r;
      out_r.total_pulses   <= tot_sat;
      out_r.timer_prescale <= period_r - 1'b1;
      out_r.pulse_reload   <= reload;
      out_r.direction_pin  <= dir_r;
      out_r.last           <= last_r;
      out_r.error          <= 1'b0;
    end else if (cmd.err) begin
      out_r.band_freq      <= '0;
      out_r.band_pulses    <= '0;
      out_r.total_pulses   <= pulse_total_r;
      out_r.timer_prescale <= '0;
      out_r.pulse_reload   <= '0;
      out_r.direction_pin  <= dir_r;
      out_r.last           <= 1'b0;
      out_r.error          <= 1'b1;
    end
  end

  always_comb begin
    sts.running   = running_r;
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.mul_done  = mul_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsp_ctrl: profiler sequencer
// Accepts a transaction, then steps the datapath through set-up, division,
// root, squaring and result phases.
// ----------------------------------------------------------------------------
`default_nettype none

module scsp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_func,
  output logic                 in_ready,
  input  wire scsp_pkg::sts_t  sts,
  output scsp_pkg::cmd_t       cmd
);
  import scsp_pkg::*;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    cmd          = '0;
    in_ready     = (state_r == ST_IDLE);
    unique case (state_r) inside
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          unique case (in_func) inside
            FUNC_ACCEL, FUNC_DECEL: state_nxt = ST_PREP;
            FUNC_NEXT: state_nxt = sts.running ? ST_DIV_T : ST_ERR;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV_N;
      end
      ST_DIV_N, ST_DIV_T, ST_DIV_P, ST_DIV_R: begin
        case (state_r)
          ST_DIV_N: cmd.div_sel = DIV_OP_N;
          ST_DIV_T: cmd.div_sel = DIV_OP_T;
          ST_DIV_P: cmd.div_sel = DIV_OP_P;
          default:  cmd.div_sel = DIV_OP_R;
        endcase
        if (!launched_r) begin
          cmd.div_start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (sts.div_done) begin
          cmd.div_cap  = 1'b1;
          launched_nxt = 1'b0;
          case (state_r)
            ST_DIV_N: state_nxt = ST_SQRT;
            ST_DIV_T: state_nxt = ST_SEL;
            ST_DIV_P: state_nxt = ST_DIV_R;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SQRT: begin
        if (!launched_r) begin
          cmd.sqrt_start = 1'b1;
          launched_nxt   = 1'b1;
        end else if (sts.sqrt_done) begin
          cmd.sqrt_cap = 1'b1;
          launched_nxt = 1'b0;
          state_nxt    = ST_DIV_T;
        end
      end
      ST_SEL: begin
        cmd.sel_seg = 1'b1;
        state_nxt   = ST_MUL_SQ;
      end
      ST_MUL_SQ, ST_MUL_C: begin
        cmd.mul_sel = (state_r == ST_MUL_SQ) ? MUL_OP_SQ : MUL_OP_C;
        if (!launched_r) begin
          cmd.mul_start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (sts.mul_done) begin
          launched_nxt = 1'b0;
          state_nxt    = (state_r == ST_MUL_SQ) ? ST_MUL_C : ST_FREQ;
        end
      end
      ST_FREQ: begin
        cmd.freq  = 1'b1;
        state_nxt = ST_DIV_P;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.err   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A divider completion only arrives while a division is outstanding
  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (launched_r && (state_r == ST_DIV_N || state_r == ST_DIV_T ||
                      state_r == ST_DIV_P || state_r == ST_DIV_R)))
    else $error("divider completion outside a division phase");

  // A multiplier completion only arrives while a product is outstanding
  a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> (launched_r && (state_r == ST_MUL_SQ || state_r == ST_MUL_C)))
    else $error("multiplier completion outside a multiply phase");

  // Next band with no profile running goes straight to the error result
  a_idle_next_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_func == FUNC_NEXT && !sts.running)
    |=> (state_r == ST_ERR))
    else $error("idle next band did not raise an error");

  // A finished band waits while the result register is occupied
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !sts.out_free) |=> (state_r == ST_FIN))
    else $error("band result left while output busy");

endmodule

`default_nettype wire

// ===== hw/rtl/s_curve_step_band_profiler.sv =====
// ----------------------------------------------------------------------------
// s_curve_step_band_profiler: S-curve stepper speed profile generator
// Emits one frequency band, or an error result, per start or next-band
// command, with pulse count, running total and timer settings.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A next-band transaction runs
// three serial divisions (band time, pulse count, timer period) and two
// shift-add products. An acceleration or deceleration start adds one more
// division and the 27-step square root that give the inflection time. The
// input is ready whenever the sequencer is idle, also while a finished
// result still waits in the output register.
// Configuration writes take effect at once and belong between transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module s_curve_step_band_profiler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire scsp_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output scsp_pkg::out_item_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [scsp_pkg::CFG_W-1:0] cfg_data
);
  import scsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the S-curve step band profiler
// Drives start and next-band commands through randomly stalled handshakes,
// predicts every band in fixed point and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import scsp_pkg::*;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT   = 20000;
  localparam int NPHASES       = 11;
  localparam int PHASE_BANDS   = 165;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Command stream waiting to be driven, bands waiting to be seen
  in_item_t  cmd_queue[$];
  out_item_t band_queue[$];

  // Register copies
  logic [SF_W-1:0]   start_hz;
  logic [SF_W-1:0]   target_hz;
  logic [JERK_W-1:0] jerk;

  // Profile state of the predictor
  bit              prof_running;
  bit              prof_decel;
  bit              prof_tail;
  longint unsigned prof_band;
  longint unsigned prof_itime;
  longint unsigned prof_infl;
  longint unsigned prof_total;
  bit              prof_dir;

  bit quiet;
  int mismatches;
  int stall_cycles;

  s_curve_step_band_profiler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // c*x*x exactly
  function automatic logic [127:0] jerk_square(longint unsigned x, longint unsigned c);
    return 128'(x) * 128'(x) * 128'(c);
  endfunction

  // c*x*x / 2^(2F+1), rounded down or up
  function automatic longint unsigned curve_offset(longint unsigned x, longint unsigned c,
                                                   bit up);
    logic [127:0] v;
    logic [127:0] q;
    bit rem;
    v = jerk_square(x, c);
    q = v >> (2 * TIME_FRAC_BITS + 1);
    rem = |(v & ((128'd1 << (2 * TIME_FRAC_BITS + 1)) - 1));
    return longint'(q) + ((up && rem) ? 1 : 0);
  endfunction

  // floor(2^F * sqrt(2d/c)) by bitwise search
  function automatic longint unsigned inflection_time(longint unsigned d, longint unsigned c);
    logic [127:0] lim;
    longint unsigned r;
    longint unsigned cand;
    lim = 128'(2 * d) << (2 * TIME_FRAC_BITS);
    r = 0;
    for (int b = TIME_FRAC_BITS + 6; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (jerk_square(cand, c) <= lim) r = cand;
    end
    return r;
  endfunction

  // Work out the next band of the running profile
  function automatic out_item_t next_band();
    out_item_t r;
    longint unsigned s, c, m, k, t, two, d, pulses, period, reload;
    longint f;
    bit last, hold;
    s = (start_hz != 0) ? start_hz : 1;
    c = (jerk != 0) ? jerk : 1;
    m = target_hz;
    k = prof_band;
    t = ((2 * k) << TIME_FRAC_BITS) / s;
    last = 1'b0;
    if (!prof_tail && t < prof_itime) begin
      f = prof_decel ? longint'(m) - longint'(curve_offset(t, c, 1'b0))
                     : longint'(s) + longint'(curve_offset(t, c, 1'b0));
    end else begin
      two = 2 * prof_itime;
      hold = t >= two;
      d = hold ? 0 : two - t;
      prof_tail = 1'b1;
      if (!prof_decel) begin
        f = 2 * longint'(prof_infl) - longint'(s) - longint'(curve_offset(d, c, 1'b1)) + 1;
        last = hold || f >= longint'(m);
      end else begin
        f = 2 * longint'(prof_infl) - longint'(m) + longint'(curve_offset(d, c, 1'b0));
        last = hold || f <= longint'(s);
      end
    end
    if (k >= BAND_MAX) last = 1'b1;
    if (f < 0) f = 0;
    if (f > FREQ_MAX) f = FREQ_MAX;
    pulses = (2 * longint'(f)) / s;
    if (pulses > PULSES_MAX) pulses = PULSES_MAX;
    prof_total += pulses;
    if (prof_total > TOTAL_MAX) prof_total = TOTAL_MAX;
    period = (f == 0) ? PULSE_CLOCK : PULSE_CLOCK / longint'(f);
    if (period == 0) period = 1;
    reload = period * pulses * 2;
    if (reload > RELOAD_MAX) reload = RELOAD_MAX;
    r.band_freq      = FREQ_W'(f);
    r.band_pulses    = PULSE_W'(pulses);
    r.total_pulses   = TOTAL_W'(prof_total);
    r.timer_prescale = PRESC_W'(period - 1);
    r.pulse_reload   = RELOAD_W'(reload);
    r.direction_pin  = prof_dir;
    r.last           = last;
    r.error          = 1'b0;
    if (k < BAND_MAX) prof_band = k + 1;
    if (last) begin
      prof_running = 1'b0;
      if (prof_decel) prof_total = 0;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted command
  task automatic predict_command(input in_item_t cmd);
    out_item_t r;
    longint unsigned s, c, m, infl, d;
    if (cmd.func == FUNC_IGNORED) return;
    if (cmd.func == FUNC_NEXT) begin
      if (prof_running) begin
        band_queue.push_back(next_band());
      end else begin
        r = '0;
        r.total_pulses  = TOTAL_W'(prof_total);
        r.direction_pin = prof_dir;
        r.error         = 1'b1;
        band_queue.push_back(r);
      end
      return;
    end
    s = (start_hz != 0) ? start_hz : 1;
    c = (jerk != 0) ? jerk : 1;
    m = target_hz;
    infl = (s + m) / 2;
    prof_decel = (cmd.func == FUNC_DECEL);
    if (!prof_decel) prof_dir = cmd.direction;
    if (prof_decel) d = (m > infl) ? m - infl : 0;
    else d = (infl > s) ? infl - s : 0;
    prof_infl = infl;
    prof_itime = inflection_time(d, c);
    prof_band = 0;
    prof_tail = 1'b0;
    prof_running = 1'b1;
    band_queue.push_back(next_band());
  endtask

  // Driver: present queued commands, with bursts of idle cycles
  always @(posedge clk) begin : drive_cmds
    int idle_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) predict_command(in_data);
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side in bursts and check each transaction
  always @(posedge clk) begin : check_bands
    int hold_left;
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (band_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected band: %p", out_data);
        end else begin
          want = band_queue.pop_front();
          if (out_data.band_freq != want.band_freq ||
              out_data.band_pulses != want.band_pulses ||
              out_data.total_pulses != want.total_pulses ||
              out_data.timer_prescale != want.timer_prescale ||
              out_data.pulse_reload != want.pulse_reload ||
              out_data.direction_pin != want.direction_pin ||
              out_data.last != want.last ||
              out_data.error != want.error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("band mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] func, input logic dir);
    in_item_t cmd;
    cmd.func = func;
    cmd.direction = dir;
    cmd_queue.push_back(cmd);
  endtask

  // Mostly whole profiles with random length, some loose commands
  task automatic queue_profiles(input int n);
    int bands;
    int nexts;
    logic [1:0] func;
    bands = 0;
    while (bands < n) begin
      if ($urandom_range(0, 6) == 0) begin
        func = 2'($urandom_range(0, 3));
        push_cmd(func, 1'($urandom));
        if (func != FUNC_IGNORED) bands++;
      end else begin
        push_cmd($urandom_range(0, 1) ? FUNC_DECEL : FUNC_ACCEL, 1'($urandom));
        nexts = $urandom_range(1, 60);
        if (nexts > n - bands - 1) nexts = n - bands - 1;
        repeat (nexts) push_cmd(FUNC_NEXT, 1'($urandom));
        bands += nexts + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_FREQ:  start_hz = val[SF_W-1:0];
      CFG_TARGET_FREQ: target_hz = val[SF_W-1:0];
      CFG_JERK:        jerk = val[JERK_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every band has come out and the sequencer has settled
  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || band_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int s_set[NPHASES] = '{1, 4000, 0, 4095, 100, 2000, 800, 1, -1, -1, 500};
    int m_set[NPHASES] = '{1, 4000, 4095, 1, 3000, 4000, 200, 4000, -1, -1, 2000};
    int j_set[NPHASES] = '{1, 65535, 0, 65535, 20000, 1, 500, 65535, -1, -1, 3000};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_START_FREQ;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    start_hz = START_FREQ_RST;
    target_hz = TARGET_FREQ_RST;
    jerk = JERK_RST;
    prof_running = 1'b0;
    prof_decel = 1'b0;
    prof_tail = 1'b0;
    prof_band = 0;
    prof_itime = 0;
    prof_infl = 0;
    prof_total = 0;
    prof_dir = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle next band, ignored selector, both starts, restart mid-profile
    push_cmd(FUNC_NEXT, 1'b1);
    push_cmd(FUNC_IGNORED, 1'b1);
    push_cmd(FUNC_ACCEL, 1'b1);
    repeat (6) push_cmd(FUNC_NEXT, 1'b0);
    push_cmd(FUNC_ACCEL, 1'b0);
    repeat (3) push_cmd(FUNC_NEXT, 1'b1);
    push_cmd(FUNC_DECEL, 1'b1);
    repeat (6) push_cmd(FUNC_NEXT, 1'b0);
    push_cmd(FUNC_IGNORED, 1'b0);
    push_cmd(FUNC_NEXT, 1'b1);
    drain();

    // Random phases over several register settings
    for (int p = 0; p < NPHASES; p++) begin
      write_reg(CFG_START_FREQ, (s_set[p] < 0) ? CFG_W'($urandom_range(1, 4000))
                                               : CFG_W'(s_set[p]));
      write_reg(CFG_TARGET_FREQ, (m_set[p] < 0) ? CFG_W'($urandom_range(1, 4000))
                                                : CFG_W'(m_set[p]));
      write_reg(CFG_JERK, (j_set[p] < 0) ? CFG_W'($urandom_range(1, 65535))
                                         : CFG_W'(j_set[p]));
      if (p == NPHASES - 1) quiet = 1'b1;
      queue_profiles(PHASE_BANDS);
      drain();
    end

    mismatches += band_queue.size();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
